// File: hw/rtl/palette_nearest_neighbor_scaler_top_assert.svh
// Assertion macros for the scaler and its port checker.
`ifndef PALETTE_NEAREST_NEIGHBOR_SCALER_TOP_ASSERT_SVH
`define PALETTE_NEAREST_NEIGHBOR_SCALER_TOP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PNNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define PNNS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/pnns_pkg.sv
package pnns_pkg;

  // Geometry
  localparam int unsigned SOURCE_SIDE = 128;
  localparam int unsigned OUTPUT_SIDE = 240;
  localparam int unsigned ROW_BYTES   = SOURCE_SIDE / 2;
  localparam int unsigned FRAME_BYTES = SOURCE_SIDE * SOURCE_SIDE / 2;

  // Field widths
  localparam int unsigned ADDR_W  = 13;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned NIB_W   = 4;

  // Raster counters and source-coordinate stepping (sx = ox*S/O, done incrementally)
  localparam int unsigned CNT_W     = $clog2(OUTPUT_SIDE);
  localparam int unsigned SX_W      = $clog2(SOURCE_SIDE);
  localparam int unsigned ACC_W     = $clog2(OUTPUT_SIDE) + 1;
  localparam int unsigned STEP_INT  = SOURCE_SIDE / OUTPUT_SIDE;
  localparam int unsigned STEP_FRAC = SOURCE_SIDE % OUTPUT_SIDE;

  // Palette registers
  localparam int unsigned PAL_REGS  = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_EMIT  = 1'b1
  } func_e;

  // One classified request on its way to the back end
  typedef struct packed {
    logic               is_emit;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  wdata;
    logic               nib_hi;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               frame_end;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hw/rtl/pnns_queue.sv
module pnns_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pnns_pkg::q_entry_t  push_data_i,
  input  logic                pop_i,
  output pnns_pkg::q_entry_t  head_o,
  output pnns_pkg::q_status_t status_o
);

  pnns_pkg::q_entry_t entries_q [pnns_pkg::Q_DEPTH];
  logic [pnns_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [pnns_pkg::Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [pnns_pkg::Q_CNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == pnns_pkg::Q_CNT_W'(pnns_pkg::Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = entries_q[rd_ptr_q];

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/pnns_front.sv
module pnns_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [pnns_pkg::ADDR_W-1:0]         byte_addr_i,
  input  logic [pnns_pkg::BYTE_W-1:0]         byte_value_i,
  input  pnns_pkg::q_status_t                 q_status_i,
  output logic                                push_o,
  output pnns_pkg::q_entry_t                  push_data_o
);

  logic [pnns_pkg::CNT_W-1:0] raster_x_q, raster_x_d;
  logic [pnns_pkg::CNT_W-1:0] raster_y_q, raster_y_d;
  logic [pnns_pkg::SX_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [pnns_pkg::ACC_W-1:0] sx_acc_q, sx_acc_d, sy_acc_q, sy_acc_d;
  logic [pnns_pkg::ACC_W-1:0] sx_sum, sy_sum;
  logic                       sx_carry, sy_carry;
  logic                       accept, is_emit, in_range, last_col, last_row;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign is_emit    = (func_i == pnns_pkg::FUNC_EMIT);
  assign in_range   = (32'(byte_addr_i) < pnns_pkg::FRAME_BYTES);
  assign last_col   = (raster_x_q == pnns_pkg::CNT_W'(pnns_pkg::OUTPUT_SIDE - 1));
  assign last_row   = (raster_y_q == pnns_pkg::CNT_W'(pnns_pkg::OUTPUT_SIDE - 1));

  // Out-of-range writes are dropped here
  assign push_o = accept && (is_emit || in_range);

  // Build the request: emits carry the sampled source address
  always_comb begin
    push_data_o.is_emit   = is_emit;
    push_data_o.wdata     = byte_value_i;
    push_data_o.nib_hi    = sx_q[0];
    push_data_o.x         = pnns_pkg::COORD_W'(raster_x_q);
    push_data_o.y         = pnns_pkg::COORD_W'(raster_y_q);
    push_data_o.frame_end = last_col && last_row;
    if (is_emit) begin
      push_data_o.addr = pnns_pkg::ADDR_W'(sy_q) * pnns_pkg::ADDR_W'(pnns_pkg::ROW_BYTES)
                       + pnns_pkg::ADDR_W'(sx_q >> 1);
    end else begin
      push_data_o.addr = byte_addr_i;
    end
  end

  // Incremental source-coordinate step: fraction accumulates modulo OUTPUT_SIDE
  assign sx_sum   = sx_acc_q + pnns_pkg::ACC_W'(pnns_pkg::STEP_FRAC);
  assign sx_carry = (32'(sx_sum) >= pnns_pkg::OUTPUT_SIDE);
  assign sy_sum   = sy_acc_q + pnns_pkg::ACC_W'(pnns_pkg::STEP_FRAC);
  assign sy_carry = (32'(sy_sum) >= pnns_pkg::OUTPUT_SIDE);

  // Raster advance on each accepted emit
  always_comb begin
    raster_x_d = raster_x_q;
    raster_y_d = raster_y_q;
    sx_d       = sx_q;
    sx_acc_d   = sx_acc_q;
    sy_d       = sy_q;
    sy_acc_d   = sy_acc_q;
    if (accept && is_emit) begin
      if (last_col) begin
        raster_x_d = '0;
        sx_d       = '0;
        sx_acc_d   = '0;
        if (last_row) begin
          raster_y_d = '0;
          sy_d       = '0;
          sy_acc_d   = '0;
        end else begin
          raster_y_d = raster_y_q + 1'b1;
          sy_d       = sy_q + pnns_pkg::SX_W'(pnns_pkg::STEP_INT) + pnns_pkg::SX_W'(sy_carry);
          sy_acc_d   = sy_carry ? sy_sum - pnns_pkg::ACC_W'(pnns_pkg::OUTPUT_SIDE) : sy_sum;
        end
      end else begin
        raster_x_d = raster_x_q + 1'b1;
        sx_d       = sx_q + pnns_pkg::SX_W'(pnns_pkg::STEP_INT) + pnns_pkg::SX_W'(sx_carry);
        sx_acc_d   = sx_carry ? sx_sum - pnns_pkg::ACC_W'(pnns_pkg::OUTPUT_SIDE) : sx_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raster_x_q <= '0;
      raster_y_q <= '0;
      sx_q       <= '0;
      sx_acc_q   <= '0;
      sy_q       <= '0;
      sy_acc_q   <= '0;
    end else begin
      raster_x_q <= raster_x_d;
      raster_y_q <= raster_y_d;
      sx_q       <= sx_d;
      sx_acc_q   <= sx_acc_d;
      sy_q       <= sy_d;
      sy_acc_q   <= sy_acc_d;
    end
  end

endmodule

// File: hw/rtl/pnns_back.sv
module pnns_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pnns_pkg::q_entry_t                  head_i,
  input  pnns_pkg::q_status_t                 q_status_i,
  output logic                                pop_o,
  input  logic                                cfg_valid_i,
  input  logic [pnns_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pnns_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pnns_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic [pnns_pkg::COORD_W-1:0]        out_x_o,
  output logic [pnns_pkg::COORD_W-1:0]        out_y_o,
  output logic                                frame_end_o
);

  logic [pnns_pkg::BYTE_W-1:0]  frame_mem [pnns_pkg::FRAME_BYTES];
  logic [pnns_pkg::CFG_W-1:0]   pal_q [pnns_pkg::PAL_REGS];

  // Read stage
  logic                         rd_valid_q, rd_valid_d;
  logic [pnns_pkg::BYTE_W-1:0]  rd_byte_q;
  logic                         rd_nib_hi_q, rd_frame_end_q;
  logic [pnns_pkg::COORD_W-1:0] rd_x_q, rd_y_q;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic [pnns_pkg::COLOR_W-1:0] color_q;
  logic [pnns_pkg::COORD_W-1:0] out_x_q, out_y_q;
  logic                         frame_end_q;

  logic                         out_free, rd_free;
  logic [pnns_pkg::NIB_W-1:0]   nib;
  logic [pnns_pkg::CFG_W-1:0]   pal_word;
  logic [pnns_pkg::COLOR_W-1:0] color;

  assign out_free = !out_valid_q || out_ready_i;
  assign rd_free  = !rd_valid_q || out_free;

  // Writes always drain; emits wait for room in the read stage
  assign pop_o = !q_status_i.empty && (!head_i.is_emit || rd_free);

  // Palette lookup on the fetched nibble
  assign nib      = rd_nib_hi_q ? rd_byte_q[7:4] : rd_byte_q[3:0];
  assign pal_word = pal_q[nib[3:2]];
  assign color    = pal_word[nib[1:0]*pnns_pkg::COLOR_W +: pnns_pkg::COLOR_W];

  // Source frame port: one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (head_i.is_emit) begin
        rd_byte_q      <= frame_mem[head_i.addr];
        rd_nib_hi_q    <= head_i.nib_hi;
        rd_x_q         <= head_i.x;
        rd_y_q         <= head_i.y;
        rd_frame_end_q <= head_i.frame_end;
      end else begin
        frame_mem[head_i.addr] <= head_i.wdata;
      end
    end
  end

  // Palette registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pnns_pkg::PAL_REGS; i++) begin
        pal_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      pal_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Stage valids
  always_comb begin
    rd_valid_d  = rd_valid_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = rd_valid_q;
      rd_valid_d  = 1'b0;
    end
    if (pop_o && head_i.is_emit) begin
      rd_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_free && rd_valid_q) begin
      color_q     <= color;
      out_x_q     <= rd_x_q;
      out_y_q     <= rd_y_q;
      frame_end_q <= rd_frame_end_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = color_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign frame_end_o   = frame_end_q;

endmodule

// File: hw/rtl/palette_nearest_neighbor_scaler_top.sv
// Nearest-neighbor upscaler from a 128x128 frame of 4-bit palette pixels
// (packed two per byte, even x in the low nibble) to a 240x240 raster of
// 16-bit panel colors. A request with func 0 stores one source byte; func 1
// emits the next raster pixel with its coordinates and an end-of-frame flag
// on the last one. The four 64-bit palette registers are written through the
// cfg port, which is always ready. The front end keeps the raster position
// and source sampling position, turns each request into a frame write or a
// frame read and puts it into a four-entry queue; the back end drains the
// queue through the single port of the 8192-byte frame memory, then looks up
// the palette. One request is taken per cycle while the queue is not full, set
// by that single memory port; an emit's pixel passes through the queue, the
// read stage and the output register, and output stalls can hold it. Writes beyond the frame are dropped.
module palette_nearest_neighbor_scaler_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [pnns_pkg::ADDR_W-1:0]         byte_addr_i,
  input  logic [pnns_pkg::BYTE_W-1:0]         byte_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pnns_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic [pnns_pkg::COORD_W-1:0]        out_x_o,
  output logic [pnns_pkg::COORD_W-1:0]        out_y_o,
  output logic                                frame_end_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pnns_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pnns_pkg::CFG_W-1:0]          cfg_data_i
);

  logic                push;
  logic                pop;
  pnns_pkg::q_entry_t  push_data;
  pnns_pkg::q_entry_t  head;
  pnns_pkg::q_status_t q_status;

  assign cfg_ready_o = 1'b1;

  pnns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .byte_addr_i  (byte_addr_i),
    .byte_value_i (byte_value_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  pnns_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  pnns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_color_o (pixel_color_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

// File: hw/rtl/pnns_port_checker.sv
`include "palette_nearest_neighbor_scaler_top_assert.svh"

module pnns_port_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic [pnns_pkg::COLOR_W-1:0]        pixel_color_o,
  input  logic [pnns_pkg::COORD_W-1:0]        out_x_o,
  input  logic [pnns_pkg::COORD_W-1:0]        out_y_o,
  input  logic                                frame_end_o
);

  logic [pnns_pkg::CNT_W-1:0] exp_x_q, exp_x_d;
  logic [pnns_pkg::CNT_W-1:0] exp_y_q, exp_y_d;
  logic                       exp_last;

  assign exp_last = (exp_x_q == pnns_pkg::CNT_W'(pnns_pkg::OUTPUT_SIDE - 1))
                 && (exp_y_q == pnns_pkg::CNT_W'(pnns_pkg::OUTPUT_SIDE - 1));

  // Track where the next pixel must land in the raster
  always_comb begin
    exp_x_d = exp_x_q;
    exp_y_d = exp_y_q;
    if (out_valid_o && out_ready_i) begin
      if (exp_x_q == pnns_pkg::CNT_W'(pnns_pkg::OUTPUT_SIDE - 1)) begin
        exp_x_d = '0;
        exp_y_d = exp_last ? '0 : exp_y_q + 1'b1;
      end else begin
        exp_x_d = exp_x_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_x_q <= '0;
      exp_y_q <= '0;
    end else begin
      exp_x_q <= exp_x_d;
      exp_y_q <= exp_y_d;
    end
  end

  `PNNS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_color_o) && $stable(out_x_o) && $stable(out_y_o), "output dropped or changed while stalled")
  `PNNS_ASSERT(a_raster_order, out_valid_o |-> (out_x_o == pnns_pkg::COORD_W'(exp_x_q)) && (out_y_o == pnns_pkg::COORD_W'(exp_y_q)), "pixel out of raster order")
  `PNNS_ASSERT(a_frame_end, out_valid_o |-> (frame_end_o == exp_last), "end-of-frame flag on wrong pixel")
  `PNNS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind palette_nearest_neighbor_scaler_top pnns_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_color_o (pixel_color_o),
  .out_x_o       (out_x_o),
  .out_y_o       (out_y_o),
  .frame_end_o   (frame_end_o)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 4;
  localparam int IDLE_SLACK      = 10;
  localparam int END_SLACK       = 20;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PHASES   = 4;
  localparam int PHASE_REQUESTS  = 250;

  typedef enum logic [pnns_pkg::CFG_IDX_W-1:0] {
    PAL_REG_0_3   = 2'd0,
    PAL_REG_4_7   = 2'd1,
    PAL_REG_8_11  = 2'd2,
    PAL_REG_12_15 = 2'd3
  } pal_reg_e;

  typedef struct packed {
    logic [pnns_pkg::COLOR_W-1:0] color;
    logic [pnns_pkg::COORD_W-1:0] x;
    logic [pnns_pkg::COORD_W-1:0] y;
    logic                         frame_end;
  } pixel_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           func_i;
  logic [pnns_pkg::ADDR_W-1:0]    byte_addr_i;
  logic [pnns_pkg::BYTE_W-1:0]    byte_value_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [pnns_pkg::COLOR_W-1:0]   pixel_color_o;
  logic [pnns_pkg::COORD_W-1:0]   out_x_o;
  logic [pnns_pkg::COORD_W-1:0]   out_y_o;
  logic                           frame_end_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [pnns_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [pnns_pkg::CFG_W-1:0]     cfg_data_i;

  // Shadow copy of the scaler: source frame, raster position, palette
  logic [pnns_pkg::BYTE_W-1:0] frame_mem [pnns_pkg::FRAME_BYTES];
  bit                          written   [pnns_pkg::FRAME_BYTES];
  logic [pnns_pkg::CFG_W-1:0]  palette   [pnns_pkg::PAL_REGS];
  int unsigned                 raster_x;
  int unsigned                 raster_y;
  pixel_t                      pending_pixels [$];

  int  fail_count;
  bit  sender_gaps;
  bit  receiver_stalls;
  int  hold_off_len;

  palette_nearest_neighbor_scaler_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .byte_addr_i   (byte_addr_i),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_color_o (pixel_color_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .frame_end_o   (frame_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Gap length: mostly short, now and then long
  function automatic int pick_gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [pnns_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pnns_pkg::BYTE_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned source_row();
    return raster_y * pnns_pkg::SOURCE_SIDE / pnns_pkg::OUTPUT_SIDE;
  endfunction

  // Byte that the next emitted pixel samples
  function automatic int unsigned raster_source_addr();
    int unsigned sx;
    sx = raster_x * pnns_pkg::SOURCE_SIDE / pnns_pkg::OUTPUT_SIDE;
    return source_row() * pnns_pkg::ROW_BYTES + sx / 2;
  endfunction

  // Update the shadow state for one accepted request; emits queue a pixel
  task automatic apply_request(pnns_pkg::func_e f, logic [pnns_pkg::ADDR_W-1:0] a,
                               logic [pnns_pkg::BYTE_W-1:0] v);
    int unsigned                 sx;
    int unsigned                 addr;
    logic [pnns_pkg::BYTE_W-1:0] b;
    logic [pnns_pkg::NIB_W-1:0]  nib;
    pixel_t                      p;
    bit                          last_col;
    bit                          last_row;
    if (f == pnns_pkg::FUNC_WRITE) begin
      if (a < pnns_pkg::FRAME_BYTES) begin
        frame_mem[a] = v;
        written[a]   = 1'b1;
      end
    end else begin
      sx   = raster_x * pnns_pkg::SOURCE_SIDE / pnns_pkg::OUTPUT_SIDE;
      addr = raster_source_addr();
      b    = (addr < pnns_pkg::FRAME_BYTES) ? frame_mem[addr] : '0;
      nib  = (sx % 2) ? b[7:4] : b[3:0];
      last_col    = (raster_x + 1 >= pnns_pkg::OUTPUT_SIDE);
      last_row    = (raster_y + 1 >= pnns_pkg::OUTPUT_SIDE);
      p.color     = palette[nib[3:2]][pnns_pkg::COLOR_W*nib[1:0] +: pnns_pkg::COLOR_W];
      p.x         = pnns_pkg::COORD_W'(raster_x);
      p.y         = pnns_pkg::COORD_W'(raster_y);
      p.frame_end = last_col && last_row;
      pending_pixels.push_back(p);
      if (last_col) begin
        raster_x = 0;
        raster_y = last_row ? 0 : raster_y + 1;
      end else begin
        raster_x = raster_x + 1;
      end
    end
  endtask

  // Offer one request, wait for it to be taken, then maybe idle
  task automatic send_request(pnns_pkg::func_e f, logic [pnns_pkg::ADDR_W-1:0] a,
                              logic [pnns_pkg::BYTE_W-1:0] v);
    int gap;
    in_valid_i   <= 1'b1;
    func_i       <= f;
    byte_addr_i  <= a;
    byte_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(f, a, v);
    gap = 0;
    if (sender_gaps && $urandom_range(0, 1)) begin
      gap = pick_gap_len();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Emit the next pixel, writing its source byte first if it is still blank
  task automatic emit_next_pixel();
    int unsigned addr;
    addr = raster_source_addr();
    if (!written[addr]) begin
      send_request(pnns_pkg::FUNC_WRITE, pnns_pkg::ADDR_W'(addr), pick_byte());
    end
    send_request(pnns_pkg::FUNC_EMIT, pnns_pkg::ADDR_W'($urandom),
                 pnns_pkg::BYTE_W'($urandom));
  endtask

  // Write a byte in the rows the raster is about to sample
  task automatic write_ahead();
    int unsigned row;
    row = source_row() + $urandom_range(0, 2);
    if (row >= pnns_pkg::SOURCE_SIDE) begin
      row = pnns_pkg::SOURCE_SIDE - 1;
    end
    send_request(pnns_pkg::FUNC_WRITE,
                 pnns_pkg::ADDR_W'(row * pnns_pkg::ROW_BYTES +
                                   $urandom_range(0, pnns_pkg::ROW_BYTES - 1)),
                 pick_byte());
  endtask

  // Sender pauses until every queued pixel has come out
  task automatic wait_for_pixels();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Fully idle: results out and trailing writes retired
  task automatic wait_idle();
    wait_for_pixels();
    repeat (IDLE_SLACK) @(posedge clk_i);
  endtask

  task automatic cfg_write(pal_reg_e idx, logic [pnns_pkg::CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    palette[idx] = data;
  endtask

  // Colors of nibble n are in bits 16n+15:16n
  task automatic load_palette(logic [pnns_pkg::PAL_REGS*pnns_pkg::CFG_W-1:0] colors);
    cfg_write(PAL_REG_0_3,   colors[0*pnns_pkg::CFG_W +: pnns_pkg::CFG_W]);
    cfg_write(PAL_REG_4_7,   colors[1*pnns_pkg::CFG_W +: pnns_pkg::CFG_W]);
    cfg_write(PAL_REG_8_11,  colors[2*pnns_pkg::CFG_W +: pnns_pkg::CFG_W]);
    cfg_write(PAL_REG_12_15, colors[3*pnns_pkg::CFG_W +: pnns_pkg::CFG_W]);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [pnns_pkg::PAL_REGS*pnns_pkg::CFG_W-1:0] random_palette();
    logic [pnns_pkg::PAL_REGS*pnns_pkg::CFG_W-1:0] colors;
    for (int i = 0; i < pnns_pkg::PAL_REGS * pnns_pkg::CFG_W / 32; i++) begin
      colors[32*i +: 32] = $urandom;
    end
    return colors;
  endfunction

  // Bytes holding every nibble value, extreme addresses and values, emits with junk fields
  task automatic test_directed();
    logic [pnns_pkg::PAL_REGS*pnns_pkg::CFG_W-1:0] colors;
    for (int n = 0; n < 16; n++) begin
      colors[pnns_pkg::COLOR_W*n +: pnns_pkg::COLOR_W] =
        pnns_pkg::COLOR_W'((16'h1111 * n) ^ 16'h0f0f);
    end
    load_palette(colors);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    for (int i = 0; i < 8; i++) begin
      send_request(pnns_pkg::FUNC_WRITE, pnns_pkg::ADDR_W'(i), {4'(2*i + 1), 4'(2*i)});
    end
    send_request(pnns_pkg::FUNC_WRITE, pnns_pkg::ADDR_W'(pnns_pkg::FRAME_BYTES - 1), 8'h00);
    send_request(pnns_pkg::FUNC_WRITE, '0, 8'hff);
    for (int i = 0; i < 14; i++) begin
      if (i % 2) begin
        send_request(pnns_pkg::FUNC_EMIT, '1, '1);
      end else begin
        send_request(pnns_pkg::FUNC_EMIT, '0, '0);
      end
    end
    wait_idle();
  endtask

  // Mostly emits with their bytes written just ahead, plus writes anywhere
  task automatic test_random_mix();
    logic [pnns_pkg::PAL_REGS*pnns_pkg::CFG_W-1:0] colors;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1:       colors = '1;
        2:       colors = '0;
        default: colors = random_palette();
      endcase
      load_palette(colors);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if (i % 100 == 0) begin
          sender_gaps     = ($urandom_range(0, 3) != 0);
          receiver_stalls = ($urandom_range(0, 3) != 0);
        end
        case ($urandom_range(0, 19))
          0, 1, 2:       send_request(pnns_pkg::FUNC_WRITE, pnns_pkg::ADDR_W'($urandom),
                                      pick_byte());
          3, 4, 5, 6, 7: write_ahead();
          default:       emit_next_pixel();
        endcase
      end
      wait_idle();
    end
  endtask

  // Receiver holds off long enough to fill the block and stall its input
  task automatic test_output_hold_off();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_off_len    = HOLD_OFF_CYCLES;
    for (int i = 0; i < 40; i++) begin
      emit_next_pixel();
    end
    wait_idle();
  endtask

  // Sender stops until the pipeline has emptied, then resumes
  task automatic test_drain_pause();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          write_ahead();
        end else begin
          emit_next_pixel();
        end
      end
      wait_for_pixels();
    end
    wait_idle();
  endtask

  // Run out the rest of the current row, check the wrap to column 0 of the next
  task automatic test_row_wrap();
    int unsigned start_row;
    load_palette(random_palette());
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    start_row       = raster_y;
    while (raster_y == start_row) begin
      emit_next_pixel();
    end
    for (int i = 0; i < 10; i++) begin
      emit_next_pixel();
    end
    wait_idle();
  endtask

  // Receiver: random stalls or a long hold-off on request
  initial begin : drive_out_ready
    int stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!receiver_stalls || $urandom_range(0, 9) < 7) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall_left = pick_gap_len() - 1;
      end
    end
  end

  // Compare each pixel taken with the oldest expected one
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel out with none expected: x %0d y %0d", out_x_o, out_y_o);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_color_o !== want.color) begin
          $error("pixel_color expected %h got %h", want.color, pixel_color_o);
          fail_count++;
        end
        if (out_x_o !== want.x) begin
          $error("out_x expected %0d got %0d", want.x, out_x_o);
          fail_count++;
        end
        if (out_y_o !== want.y) begin
          $error("out_y expected %0d got %0d", want.y, out_y_o);
          fail_count++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end expected %b got %b", want.frame_end, frame_end_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long with no request moving on any channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("palette_nearest_neighbor_scaler_top: mismatch");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    func_i           = pnns_pkg::FUNC_WRITE;
    byte_addr_i      = '0;
    byte_value_i     = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = PAL_REG_0_3;
    cfg_data_i       = '0;
    fail_count       = 0;
    sender_gaps      = 1'b0;
    receiver_stalls  = 1'b0;
    hold_off_len     = 0;
    raster_x         = 0;
    raster_y         = 0;
    for (int i = 0; i < pnns_pkg::PAL_REGS; i++) begin
      palette[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix();
    test_output_hold_off();
    test_drain_pause();
    test_row_wrap();

    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (END_SLACK) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("palette_nearest_neighbor_scaler_top: match");
    end else begin
      $display("palette_nearest_neighbor_scaler_top: mismatch");
    end
    $finish;
  end

endmodule
